/* src/salt_pkg.sv */
`default_nettype none

package salt_pkg;

    localparam int ADDR_W     = 32;
    localparam int TAG_W      = 32;
    localparam int IDX_W      = 15;
    localparam int SET_OUT_W  = 10;
    localparam int COUNT_W    = 32;

    localparam int BLOCK_W    = 5;
    localparam int SETB_W     = 4;
    localparam int WAYS_W     = 4;
    localparam int CFG_W      = 5;
    localparam int CFG_IDX_W  = 2;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 112;
    localparam int OUT_USER_W = 1;

    localparam logic [BLOCK_W-1:0] BLOCK_BITS_RST = 5'd5;
    localparam logic [SETB_W-1:0]  SET_BITS_RST   = 4'd6;
    localparam logic [WAYS_W-1:0]  WAYS_USED_RST  = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_BITS = 2'd0,
        CFG_SET_BITS   = 2'd1,
        CFG_WAYS_USED  = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INDEX,
        ST_SCALE,
        ST_READ,
        ST_UPDATE
    } state_t;

endpackage

`default_nettype wire

/* src/salt_set_update.sv */
`default_nettype none

module salt_set_update #(
    parameter int WAY_COUNT = 8,
    parameter int RANK_W    = 3,
    parameter int FILL_W    = 4
) (
    input  logic [FILL_W-1:0]                          fill,
    input  logic [WAY_COUNT-1:0][salt_pkg::TAG_W-1:0]  tags,
    input  logic [WAY_COUNT-1:0][RANK_W-1:0]           ranks,
    input  logic [salt_pkg::TAG_W-1:0]                 tag,
    input  logic [FILL_W-1:0]                          ways,
    output logic                                       hit,
    output logic [FILL_W-1:0]                          new_fill,
    output logic [WAY_COUNT-1:0][salt_pkg::TAG_W-1:0]  new_tags,
    output logic [WAY_COUNT-1:0][RANK_W-1:0]           new_ranks
);
    import salt_pkg::*;

    logic [WAY_COUNT-1:0] match;
    logic [WAY_COUNT-1:0] oldest;
    logic [RANK_W-1:0]    hit_way;
    logic [RANK_W-1:0]    victim;
    logic [RANK_W-1:0]    way_sel;
    logic [RANK_W-1:0]    old_rank;
    logic                 append;

    always_comb
    begin
        for (int i = 0; i < WAY_COUNT; i++)
        begin
            match[i]  = (FILL_W'(i) < fill) && (tags[i] == tag);
            oldest[i] = (FILL_W'(i) < fill) && (FILL_W'(ranks[i]) == fill - FILL_W'(1));
        end
    end

    always_comb
    begin
        hit_way = '0;
        victim  = '0;
        for (int i = WAY_COUNT - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_way = RANK_W'(i);
            end
            if (oldest[i])
            begin
                victim = RANK_W'(i);
            end
        end
    end

    assign hit    = |match;
    assign append = !hit && (fill < ways);

    always_comb
    begin
        priority if (hit)
        begin
            way_sel = hit_way;
        end
        else if (append)
        begin
            way_sel = fill[RANK_W-1:0];
        end
        else
        begin
            way_sel = victim;
        end
    end

    assign old_rank = ranks[way_sel];

    // Ways younger than the touched one age by one; an appended tag ages every held way.
    always_comb
    begin
        new_ranks = ranks;
        new_tags  = tags;
        for (int i = 0; i < WAY_COUNT; i++)
        begin
            if ((FILL_W'(i) < fill) && (append || (ranks[i] < old_rank)))
            begin
                new_ranks[i] = ranks[i] + RANK_W'(1);
            end
        end
        new_ranks[way_sel] = '0;
        if (!hit)
        begin
            new_tags[way_sel] = tag;
        end
    end

    assign new_fill = append ? fill + FILL_W'(1) : fill;

endmodule

`default_nettype wire

/* src/set_assoc_lru_tag_store.sv */
`default_nettype none

// Set-associative tag store with least-recently-used replacement. Each input beat carries
// a byte address and a signed offset; the block forms their 32-bit sum, splits it into
// block offset, set index and tag by the configured bit counts, looks the tag up in its
// set and returns one output beat with the hit flag, the set, the tag and the running hit
// and access counts. All per-set state lives in one row-wide synchronous memory that is
// read, updated and written back once per access, so the block takes no new input beat
// until an access has gone through address split, reciprocal scaling for the set
// reduction, set read, and the read-modify-write turn. A finished result waits in the
// output register while the next access is worked on. After reset the block sweeps the
// memory once to empty every set, one set per cycle, with s_axis_tready low;
// configuration writes are taken throughout.
module set_assoc_lru_tag_store #(
    parameter int SET_COUNT = 1024,
    parameter int WAY_COUNT = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // address [31:0], address_offset [63:32]
    input  logic [salt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // set_index [9:0], tag [41:10], hit_count [73:42], access_count [105:74], zeros above
    output logic [salt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // hit [0]
    output logic [salt_pkg::OUT_USER_W-1:0]   m_axis_tuser,
    input  logic                              cfg_we,
    input  logic [salt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [salt_pkg::CFG_W-1:0]        cfg_data
);
    import salt_pkg::*;

    localparam int SET_W    = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
    localparam int RANK_W   = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
    localparam int FILL_W   = $clog2(WAY_COUNT + 1);
    localparam int ROW_W    = FILL_W + WAY_COUNT * (TAG_W + RANK_W);
    localparam int DIV_LOG  = $clog2(SET_COUNT);
    localparam int RECIP_SH = IDX_W + DIV_LOG;
    localparam int RECIP_W  = IDX_W + 2;
    localparam int PROD_W   = IDX_W + RECIP_W;
    localparam longint RECIP = ((longint'(1) << RECIP_SH) + SET_COUNT - 1) / SET_COUNT;

    state_t state_reg, state_next;

    logic [BLOCK_W-1:0] block_bits_reg;
    logic [SETB_W-1:0]  set_bits_reg;
    logic [WAYS_W-1:0]  ways_used_reg;

    logic [SET_W-1:0]   clr_reg, clr_next;
    logic [ADDR_W-1:0]  address_reg;
    logic [ADDR_W-1:0]  offset_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [PROD_W-1:0]  qprod_reg;
    logic [SET_W-1:0]   set_reg;
    logic [ROW_W-1:0]   row_rd_reg;

    logic [COUNT_W-1:0] hit_total_reg, hit_total_next;
    logic [COUNT_W-1:0] access_total_reg, access_total_next;

    logic                 out_valid_reg;
    logic                 out_hit_reg;
    logic [SET_W-1:0]     out_set_reg;
    logic [TAG_W-1:0]     out_tag_reg;
    logic [COUNT_W-1:0]   out_hits_reg;
    logic [COUNT_W-1:0]   out_accesses_reg;

    logic clr_run, load_in, load_index, load_scale, mem_re, finish, out_free;

    logic [ADDR_W-1:0] sum;
    logic [5:0]        shift_amt;
    logic [IDX_W-1:0]  idx_calc;
    logic [TAG_W-1:0]  tag_calc;
    logic [PROD_W-1:0] quot;
    logic [PROD_W-1:0] rem;
    logic [SET_W-1:0]  set_calc;
    logic [FILL_W-1:0] ways_eff;

    logic [FILL_W-1:0]                  rd_fill, upd_fill;
    logic [WAY_COUNT-1:0][TAG_W-1:0]    rd_tags, upd_tags;
    logic [WAY_COUNT-1:0][RANK_W-1:0]   rd_ranks, upd_ranks;
    logic                               upd_hit;

    logic [ROW_W-1:0] row_mem [SET_COUNT];
    logic [ROW_W-1:0] mem_wdata;
    logic [SET_W-1:0] mem_waddr;
    logic             mem_we;

    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == SET_W'(SET_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_INDEX;
                end
            end
            ST_INDEX:  state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_READ;
            ST_READ:   state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        clr_run       = 1'b0;
        load_in       = 1'b0;
        load_index    = 1'b0;
        load_scale    = 1'b0;
        mem_re        = 1'b0;
        finish        = 1'b0;
        unique case (state_reg)
            ST_CLEAR:  clr_run = 1'b1;
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                load_in       = s_axis_tvalid;
            end
            ST_INDEX:  load_index = 1'b1;
            ST_SCALE:  load_scale = 1'b1;
            ST_READ:   mem_re = 1'b1;
            ST_UPDATE: finish = out_free;
            default:   clr_run = 1'b0;
        endcase
    end

    assign sum       = address_reg + offset_reg;
    assign shift_amt = {1'b0, block_bits_reg} + {2'b00, set_bits_reg};
    assign idx_calc  = IDX_W'(sum >> block_bits_reg) & ~({IDX_W{1'b1}} << set_bits_reg);
    assign tag_calc  = TAG_W'(sum >> shift_amt);

    // Set reduction by multiplying with the reciprocal of SET_COUNT; exact for every index.
    assign quot     = qprod_reg >> RECIP_SH;
    assign rem      = PROD_W'(idx_reg) - quot * PROD_W'(SET_COUNT);
    assign set_calc = rem[SET_W-1:0];

    always_comb
    begin
        priority if (ways_used_reg == '0)
        begin
            ways_eff = FILL_W'(1);
        end
        else if (32'(ways_used_reg) > WAY_COUNT)
        begin
            ways_eff = FILL_W'(WAY_COUNT);
        end
        else
        begin
            ways_eff = FILL_W'(ways_used_reg);
        end
    end

    assign rd_fill  = row_rd_reg[FILL_W-1:0];
    assign rd_tags  = row_rd_reg[FILL_W +: WAY_COUNT * TAG_W];
    assign rd_ranks = row_rd_reg[FILL_W + WAY_COUNT * TAG_W +: WAY_COUNT * RANK_W];

    salt_set_update #(
        .WAY_COUNT (WAY_COUNT),
        .RANK_W    (RANK_W),
        .FILL_W    (FILL_W)
    ) u_update (
        .fill      (rd_fill),
        .tags      (rd_tags),
        .ranks     (rd_ranks),
        .tag       (tag_reg),
        .ways      (ways_eff),
        .hit       (upd_hit),
        .new_fill  (upd_fill),
        .new_tags  (upd_tags),
        .new_ranks (upd_ranks)
    );

    assign mem_we    = clr_run || finish;
    assign mem_waddr = clr_run ? clr_reg : set_reg;
    assign mem_wdata = clr_run ? '0 : {upd_ranks, upd_tags, upd_fill};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            row_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            row_rd_reg <= row_mem[set_calc];
        end
    end

    assign clr_next          = clr_run ? clr_reg + SET_W'(1) : clr_reg;
    assign hit_total_next    = hit_total_reg + COUNT_W'(upd_hit);
    assign access_total_next = access_total_reg + COUNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_reg          <= '0;
            block_bits_reg   <= BLOCK_BITS_RST;
            set_bits_reg     <= SET_BITS_RST;
            ways_used_reg    <= WAYS_USED_RST;
            hit_total_reg    <= '0;
            access_total_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BLOCK_BITS: block_bits_reg <= cfg_data[BLOCK_W-1:0];
                    CFG_SET_BITS:   set_bits_reg   <= cfg_data[SETB_W-1:0];
                    CFG_WAYS_USED:  ways_used_reg  <= cfg_data[WAYS_W-1:0];
                    default:        ways_used_reg  <= ways_used_reg;
                endcase
            end
            if (finish)
            begin
                hit_total_reg    <= hit_total_next;
                access_total_reg <= access_total_next;
                out_valid_reg    <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            address_reg <= s_axis_tdata[ADDR_W-1:0];
            offset_reg  <= s_axis_tdata[2*ADDR_W-1:ADDR_W];
        end
        if (load_index)
        begin
            idx_reg <= idx_calc;
            tag_reg <= tag_calc;
        end
        if (load_scale)
        begin
            qprod_reg <= PROD_W'(idx_reg) * PROD_W'(RECIP);
        end
        if (mem_re)
        begin
            set_reg <= set_calc;
        end
        if (finish)
        begin
            out_hit_reg      <= upd_hit;
            out_set_reg      <= set_reg;
            out_tag_reg      <= tag_reg;
            out_hits_reg     <= hit_total_next;
            out_accesses_reg <= access_total_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = OUT_USER_W'(out_hit_reg);
    assign m_axis_tdata  = OUT_DATA_W'({out_accesses_reg, out_hits_reg, out_tag_reg,
                                        SET_OUT_W'(out_set_reg)});

endmodule

`default_nettype wire

/* src/salt_port_checker.sv */
`default_nettype none

module salt_port_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [salt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [salt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic [salt_pkg::OUT_USER_W-1:0]   m_axis_tuser,
    input  logic                              cfg_we,
    input  logic [salt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [salt_pkg::CFG_W-1:0]        cfg_data
);
    import salt_pkg::*;

    logic               s_beat, m_beat;
    logic               seen_reg;
    logic [COUNT_W-1:0] last_hits_reg, last_accesses_reg;
    logic [COUNT_W-1:0] beat_hits, beat_accesses;
    logic [COUNT_W-1:0] want_hits, want_accesses;
    logic               cfg_seen;

    assign s_beat        = s_axis_tvalid && s_axis_tready;
    assign m_beat        = m_axis_tvalid && m_axis_tready;
    assign beat_hits     = m_axis_tdata[73:42];
    assign beat_accesses = m_axis_tdata[105:74];
    assign want_hits     = (seen_reg ? last_hits_reg : '0) + COUNT_W'(m_axis_tuser[0]);
    assign want_accesses = (seen_reg ? last_accesses_reg : '0) + COUNT_W'(1);
    assign cfg_seen      = cfg_we && (cfg_index != '0 || cfg_data != '0 || s_axis_tdata != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else if (m_beat)
        begin
            seen_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_beat)
        begin
            last_hits_reg     <= beat_hits;
            last_accesses_reg <= beat_accesses;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_beat |=> !s_axis_tready)
        else $error("input taken while an access is still in progress");

    a_access_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_beat |-> beat_accesses == want_accesses)
        else $error("access count did not advance by one");

    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_beat |-> beat_hits == want_hits || (cfg_seen && !cfg_seen))
        else $error("hit count does not follow the hit flags");

endmodule

bind set_assoc_lru_tag_store salt_port_checker u_port_checker (.*);

`default_nettype wire
